FILE: rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the two-queue shared slot pool.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int POOL_SLOTS_DEF  = 16;
  localparam int HANDLE_BITS_DEF = 8;
  localparam int HANDLE_OUT_BITS = 8;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic       operation;
    logic       queue_select;
    logic [7:0] process_handle;
  } in_word_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] handle_out;
  } out_word_t;

endpackage

FILE: rtl/spq_slot_mem.sv
// ----------------------------------------------------------------------------
// spq_slot_mem
// Slot storage: handle memory and link memory, one write port each and a
// shared registered read port.
// ----------------------------------------------------------------------------
module spq_slot_mem #(
  parameter int POOL_SLOTS  = 16,
  parameter int HANDLE_BITS = 8,
  localparam int SLOT_BITS  = $clog2(POOL_SLOTS)
) (
  input  logic                   clk,
  input  logic                   hwr_en,
  input  logic [SLOT_BITS-1:0]   hwr_addr,
  input  logic [HANDLE_BITS-1:0] hwr_data,
  input  logic                   lwr_en,
  input  logic [SLOT_BITS-1:0]   lwr_addr,
  input  logic [SLOT_BITS-1:0]   lwr_data,
  input  logic                   rd_en,
  input  logic [SLOT_BITS-1:0]   rd_addr,
  output logic [HANDLE_BITS-1:0] rd_handle,
  output logic [SLOT_BITS-1:0]   rd_next
);

  logic [HANDLE_BITS-1:0] handle_mem [POOL_SLOTS];
  logic [SLOT_BITS-1:0]   link_mem   [POOL_SLOTS];

  always_ff @(posedge clk) begin
    if (hwr_en) begin
      handle_mem[hwr_addr] <= hwr_data;
    end
    if (rd_en) begin
      rd_handle <= handle_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (lwr_en) begin
      link_mem[lwr_addr] <= lwr_data;
    end
    if (rd_en) begin
      rd_next <= link_mem[rd_addr];
    end
  end

endmodule

FILE: rtl/spq_free_find.sv
// ----------------------------------------------------------------------------
// spq_free_find
// Registered search for the lowest-numbered free slot in the occupancy map.
// ----------------------------------------------------------------------------
module spq_free_find #(
  parameter int POOL_SLOTS = 16,
  localparam int SLOT_BITS = $clog2(POOL_SLOTS)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [POOL_SLOTS-1:0] in_use,
  output logic                  free_any_r,
  output logic [SLOT_BITS-1:0]  free_idx_r
);

  logic                 free_any_nxt;
  logic [SLOT_BITS-1:0] free_idx_nxt;

  always_comb begin
    free_any_nxt = 1'b0;
    free_idx_nxt = '0;
    for (int i = POOL_SLOTS - 1; i >= 0; i--) begin
      if (!in_use[i]) begin
        free_any_nxt = 1'b1;
        free_idx_nxt = SLOT_BITS'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_any_r <= 1'b1;
      free_idx_r <= '0;
    end else begin
      free_any_r <= free_any_nxt;
      free_idx_r <= free_idx_nxt;
    end
  end

endmodule

FILE: rtl/shared_pool_two_fifo_queues_core.sv
// ----------------------------------------------------------------------------
// shared_pool_two_fifo_queues_core
// Ready and blocked FIFO queues kept as linked lists over one slot pool.
//
// A command word is taken on in_word at a clock edge where start is high and
// busy is low. operation enqueue claims the lowest free slot, stores the
// handle and links it after the tail of the selected queue; operation
// dequeue unlinks the head slot, frees it and returns its handle.
// Each command gives one result word on out_word, marked by a one-cycle
// out_valid strobe: status done, pool full (enqueue dropped) or queue empty.
// For enqueue and empty dequeue out_valid is registered from state S_EXEC;
// a successful dequeue first passes through S_POP for the registered read
// of the slot memories, and out_valid is registered from S_POP.
// busy is high from the accept edge until out_valid rises; a new command can
// be taken at the edge that ends the result cycle, so a new command is never
// taken while the last one is still in progress.
// The free slot search is registered from the occupancy map.
// Reset (synchronous, rst_n low) frees every slot and empties both queues;
// the slot memories need no clearing. The receiver cannot stall.
// ----------------------------------------------------------------------------
module shared_pool_two_fifo_queues_core #(
  parameter int POOL_SLOTS  = spq_pkg::POOL_SLOTS_DEF,
  parameter int HANDLE_BITS = spq_pkg::HANDLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  spq_pkg::in_word_t  in_word,
  output logic               out_valid,
  output spq_pkg::out_word_t out_word
);

  import spq_pkg::*;

  localparam int SLOT_BITS = $clog2(POOL_SLOTS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_POP
  } state_t;

  state_t               state_r, state_nxt;
  in_word_t             in_r, in_nxt;
  out_word_t            out_r, out_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [SLOT_BITS-1:0] head_r [2];
  logic [SLOT_BITS-1:0] head_nxt [2];
  logic [SLOT_BITS-1:0] tail_r [2];
  logic [SLOT_BITS-1:0] tail_nxt [2];
  logic [1:0]           nonempty_r, nonempty_nxt;
  logic [POOL_SLOTS-1:0] in_use_r, in_use_nxt;

  logic                   free_any_r;
  logic [SLOT_BITS-1:0]   free_idx_r;
  logic                   hwr_en, lwr_en, rd_en;
  logic [HANDLE_BITS-1:0] rd_handle;
  logic [SLOT_BITS-1:0]   rd_next;
  logic [SLOT_BITS-1:0]   cur_head, cur_tail;
  logic                   accept;
  logic                   enq_ok;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  assign cur_head = head_r[in_r.queue_select];
  assign cur_tail = tail_r[in_r.queue_select];

  assign enq_ok = (state_r == S_EXEC) && (in_r.operation == OP_ENQ) && free_any_r;
  assign hwr_en = enq_ok;
  assign lwr_en = enq_ok && nonempty_r[in_r.queue_select];
  assign rd_en  = (state_r == S_EXEC) && (in_r.operation == OP_DEQ);

  spq_free_find #(
    .POOL_SLOTS (POOL_SLOTS)
  ) u_free_find (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_use     (in_use_r),
    .free_any_r (free_any_r),
    .free_idx_r (free_idx_r)
  );

  spq_slot_mem #(
    .POOL_SLOTS  (POOL_SLOTS),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_slot_mem (
    .clk       (clk),
    .hwr_en    (hwr_en),
    .hwr_addr  (free_idx_r),
    .hwr_data  (HANDLE_BITS'(in_r.process_handle)),
    .lwr_en    (lwr_en),
    .lwr_addr  (cur_tail),
    .lwr_data  (free_idx_r),
    .rd_en     (rd_en),
    .rd_addr   (cur_head),
    .rd_handle (rd_handle),
    .rd_next   (rd_next)
  );

  always_comb begin
    state_nxt     = state_r;
    in_nxt        = in_r;
    out_nxt       = out_r;
    out_valid_nxt = 1'b0;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    nonempty_nxt  = nonempty_r;
    in_use_nxt    = in_use_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          in_nxt    = in_word;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (in_r.operation == OP_ENQ) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_nxt.handle_out = '0;
          if (!free_any_r) begin
            out_nxt.status = ST_FULL;
          end else begin
            out_nxt.status = ST_DONE;
            in_use_nxt[free_idx_r] = 1'b1;
            tail_nxt[in_r.queue_select] = free_idx_r;
            if (!nonempty_r[in_r.queue_select]) begin
              head_nxt[in_r.queue_select]     = free_idx_r;
              nonempty_nxt[in_r.queue_select] = 1'b1;
            end
          end
        end else if (!nonempty_r[in_r.queue_select]) begin
          state_nxt          = S_IDLE;
          out_valid_nxt      = 1'b1;
          out_nxt.status     = ST_EMPTY;
          out_nxt.handle_out = '0;
        end else begin
          state_nxt = S_POP;
        end
      end
      S_POP: begin
        state_nxt          = S_IDLE;
        out_valid_nxt      = 1'b1;
        out_nxt.status     = ST_DONE;
        out_nxt.handle_out = HANDLE_OUT_BITS'(rd_handle);
        in_use_nxt[cur_head] = 1'b0;
        if (cur_head == cur_tail) begin
          nonempty_nxt[in_r.queue_select] = 1'b0;
          head_nxt[in_r.queue_select]     = '0;
          tail_nxt[in_r.queue_select]     = '0;
        end else begin
          head_nxt[in_r.queue_select] = rd_next;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      head_r      <= '{default: '0};
      tail_r      <= '{default: '0};
      nonempty_r  <= '0;
      in_use_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      nonempty_r  <= nonempty_nxt;
      in_use_r    <= in_use_nxt;
    end
    in_r  <= in_nxt;
    out_r <= out_nxt;
  end

  // empty ready queue holds cleared pointers
  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    !nonempty_r[0] |-> (head_r[0] == '0) && (tail_r[0] == '0))
    else $error("empty ready queue with stale pointers");

  // head of a live blocked queue is an occupied slot
  a_head_in_use: assert property (@(posedge clk) disable iff (!rst_n)
    nonempty_r[1] |-> in_use_r[head_r[1]])
    else $error("blocked queue head points at a free slot");

  // successful enqueue claims exactly one slot
  a_claim_one: assert property (@(posedge clk) disable iff (!rst_n)
    enq_ok |=> $countones(in_use_r) == $past($countones(in_use_r)) + 1)
    else $error("enqueue did not claim exactly one slot");

  // result strobe only on return to idle
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == S_IDLE)
    else $error("result shown while still busy");

endmodule

FILE: test/tb_shared_pool_two_fifo_queues_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_shared_pool_two_fifo_queues_core
// Self-checking bench for the ready/blocked queues over one shared slot pool.
//
// A short table of directed commands covers the empty queues, the extreme
// handles and a full pool. A long random run follows, switching between fill
// and drain phases so that the pool overflows and both queues run dry many
// times. Every result word is checked against a bench-side model of the two
// linked lists, or a table row's expected word. The sender idles at random.
// One stretch has no idling, and once the sender waits for all pending results.
// ----------------------------------------------------------------------------
module tb_shared_pool_two_fifo_queues_core;
  import spq_pkg::*;

  localparam int SLOTS = POOL_SLOTS_DEF;
  localparam int LINK_BITS = $clog2(SLOTS);
  localparam logic Q_READY = 1'b0;
  localparam logic Q_BLOCKED = 1'b1;
  localparam int RAND_WORDS = 1950;
  localparam int STALL_LIMIT = 5000;

  typedef struct {
    in_word_t  w;
    logic      typed;
    out_word_t exp;
  } row_t;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_word_t  in_word;
  logic      out_valid;
  out_word_t out_word;

  logic [HANDLE_BITS_DEF-1:0] slot_hdl [SLOTS];
  logic [LINK_BITS-1:0]       slot_link [SLOTS];
  logic [SLOTS-1:0]           slot_used;
  logic [LINK_BITS-1:0]       q_head [2];
  logic [LINK_BITS-1:0]       q_tail [2];
  logic [1:0]                 q_live;

  out_word_t pending_results [$];
  out_word_t seen_exp;
  row_t      dir_rows [25];
  int        err_count;
  int        n_cmds;
  int        n_full;
  int        n_empty;
  int        n_popped;
  int        stall_cycles;

  shared_pool_two_fifo_queues_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_word (out_word)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic out_word_t sched_predict(in_word_t w);
    out_word_t            r;
    int                   sel;
    int                   free_slot;
    logic [LINK_BITS-1:0] hd;
    r = '0;
    sel = int'(w.queue_select);
    free_slot = -1;
    if (w.operation == OP_ENQ) begin
      for (int s = SLOTS - 1; s >= 0; s--) begin
        if (!slot_used[s]) free_slot = s;
      end
      if (free_slot < 0) begin
        r.status = ST_FULL;
        n_full++;
      end else begin
        slot_used[free_slot] = 1'b1;
        slot_hdl[free_slot] = w.process_handle;
        slot_link[free_slot] = '0;
        if (q_live[sel]) begin
          slot_link[q_tail[sel]] = LINK_BITS'(free_slot);
        end else begin
          q_head[sel] = LINK_BITS'(free_slot);
          q_live[sel] = 1'b1;
        end
        q_tail[sel] = LINK_BITS'(free_slot);
        r.status = ST_DONE;
      end
    end else if (!q_live[sel]) begin
      r.status = ST_EMPTY;
      n_empty++;
    end else begin
      hd = q_head[sel];
      r.handle_out = slot_hdl[hd];
      if (hd == q_tail[sel]) begin
        q_live[sel] = 1'b0;
        q_head[sel] = '0;
        q_tail[sel] = '0;
      end else begin
        q_head[sel] = slot_link[hd];
      end
      slot_used[hd] = 1'b0;
      slot_link[hd] = '0;
      r.status = ST_DONE;
      n_popped++;
    end
    return r;
  endfunction

  function automatic row_t mk_row(logic op, logic q, logic [7:0] h, logic typed,
                                  logic [1:0] st, logic [7:0] ho);
    row_t r;
    r.w.operation = op;
    r.w.queue_select = q;
    r.w.process_handle = h;
    r.typed = typed;
    r.exp.status = st;
    r.exp.handle_out = ho;
    return r;
  endfunction

  task automatic issue_word(input in_word_t w, input logic typed,
                            input out_word_t typed_exp, input logic may_idle);
    out_word_t e;
    if (may_idle && $urandom_range(99) < 9) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
    e = sched_predict(w);
    if (typed) e = typed_exp;
    pending_results.push_back(e);
    n_cmds++;
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing pending: status %0d handle_out %0h",
               out_word.status, out_word.handle_out);
        err_count++;
      end else begin
        seen_exp = pending_results.pop_front();
        if (out_word.status !== seen_exp.status) begin
          $error("status: expected %0d, actual %0d", seen_exp.status, out_word.status);
          err_count++;
        end
        if (out_word.handle_out !== seen_exp.handle_out) begin
          $error("handle_out: expected %0h, actual %0h",
                 seen_exp.handle_out, out_word.handle_out);
          err_count++;
        end
      end
    end
  end

  // watchdog on cycles with no word moving either way
  always @(posedge clk) begin
    if (rst_n && ((start && !busy) || out_valid)) begin
      stall_cycles <= 0;
    end else if (rst_n) begin
      if (stall_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    in_word_t w;
    int       enq_pct;
    logic     idle_ok;
    rst_n = 1'b0;
    start = 1'b0;
    in_word = '0;
    n_cmds = 0;
    n_full = 0;
    n_empty = 0;
    n_popped = 0;
    slot_used = '0;
    q_live = '0;
    for (int i = 0; i < 2; i++) begin
      q_head[i] = '0;
      q_tail[i] = '0;
    end
    for (int i = 0; i < SLOTS; i++) begin
      slot_hdl[i] = '0;
      slot_link[i] = '0;
    end

    dir_rows = '{
      mk_row(OP_DEQ, Q_READY,   8'h00, 1'b1, ST_EMPTY, 8'h00),
      mk_row(OP_DEQ, Q_BLOCKED, 8'hFF, 1'b1, ST_EMPTY, 8'h00),
      mk_row(OP_ENQ, Q_READY,   8'h00, 1'b1, ST_DONE,  8'h00),
      mk_row(OP_ENQ, Q_BLOCKED, 8'hFF, 1'b1, ST_DONE,  8'h00),
      mk_row(OP_DEQ, Q_BLOCKED, 8'h00, 1'b1, ST_DONE,  8'hFF),
      mk_row(OP_DEQ, Q_READY,   8'hFF, 1'b1, ST_DONE,  8'h00),
      mk_row(OP_DEQ, Q_READY,   8'h00, 1'b1, ST_EMPTY, 8'h00),
      mk_row(OP_ENQ, Q_READY,   8'h01, 1'b0, ST_DONE,  8'h00),
      mk_row(OP_ENQ, Q_BLOCKED, 8'h02, 1'b0, ST_DONE,  8'h00),
      mk_row(OP_ENQ, Q_READY,   8'h04, 1'b0, ST_DONE,  8'h00),
      mk_row(OP_ENQ, Q_BLOCKED, 8'h08, 1'b0, ST_DONE,  8'h00),
      mk_row(OP_ENQ, Q_READY,   8'h10, 1'b0, ST_DONE,  8'h00),
      mk_row(OP_ENQ, Q_BLOCKED, 8'h20, 1'b0, ST_DONE,  8'h00),
      mk_row(OP_ENQ, Q_READY,   8'h40, 1'b0, ST_DONE,  8'h00),
      mk_row(OP_ENQ, Q_BLOCKED, 8'h80, 1'b0, ST_DONE,  8'h00),
      mk_row(OP_ENQ, Q_READY,   8'hFE, 1'b0, ST_DONE,  8'h00),
      mk_row(OP_ENQ, Q_BLOCKED, 8'hFD, 1'b0, ST_DONE,  8'h00),
      mk_row(OP_ENQ, Q_READY,   8'hFB, 1'b0, ST_DONE,  8'h00),
      mk_row(OP_ENQ, Q_BLOCKED, 8'hF7, 1'b0, ST_DONE,  8'h00),
      mk_row(OP_ENQ, Q_READY,   8'hEF, 1'b0, ST_DONE,  8'h00),
      mk_row(OP_ENQ, Q_BLOCKED, 8'hDF, 1'b0, ST_DONE,  8'h00),
      mk_row(OP_ENQ, Q_READY,   8'hBF, 1'b0, ST_DONE,  8'h00),
      mk_row(OP_ENQ, Q_BLOCKED, 8'h7F, 1'b0, ST_DONE,  8'h00),
      mk_row(OP_ENQ, Q_READY,   8'h55, 1'b1, ST_FULL,  8'h00),
      mk_row(OP_DEQ, Q_BLOCKED, 8'hAA, 1'b0, ST_DONE,  8'h00)
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      issue_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].exp, 1'b1);
    end

    // alternate fill-heavy and drain-heavy phases so full and empty both recur
    for (int i = 0; i < RAND_WORDS; i++) begin
      if (i == 1000) begin
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
      enq_pct = ((i / 150) % 2 == 0) ? 75 : 25;
      idle_ok = !(i >= 600 && i < 900);
      w.operation = ($urandom_range(99) < enq_pct) ? OP_ENQ : OP_DEQ;
      w.queue_select = 1'($urandom_range(1));
      w.process_handle = 8'($urandom_range(255));
      issue_word(w, 1'b0, '0, idle_ok);
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("ran %0d command words: %0d handles dequeued, %0d dropped on a full pool,",
             n_cmds, n_popped, n_full);
    $display("%0d dequeues from an empty queue, with random sender gaps", n_empty);
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
